// ----- rtl/ascii_radix_prefixed_integer_parser_core_macros.svh -----
// Assertion macros for the ASCII radix-prefixed integer parser.
`ifndef ASCII_RADIX_PREFIXED_INTEGER_PARSER_CORE_MACROS_SVH
`define ASCII_RADIX_PREFIXED_INTEGER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ARPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ARPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/arpi_pkg.sv -----
// Shared types and constants for the ASCII radix-prefixed integer parser.
`timescale 1ns / 1ps
`default_nettype none

package arpi_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int CHAR_BITS   = 8;
    localparam int DIGIT_BITS  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_BITS-1:0] CH_PCT    = 8'h25;
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_ONE    = 8'h31;
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LC_F   = 8'h66;
    localparam logic [CHAR_BITS-1:0] CASE_BIT  = 8'h20;

    typedef enum logic [1:0] {
        OP_DIGIT,
        OP_NEG,
        OP_TERM
    } t_op_kind;

    typedef enum logic [1:0] {
        RADIX_BIN,
        RADIX_DEC,
        RADIX_HEX
    } t_radix;

    // One word of work passed from the front end to the back end.
    typedef struct packed {
        t_op_kind               kind;
        t_radix                 radix;
        logic [DIGIT_BITS-1:0]  digit;
        logic                   ok;
    } t_op;

endpackage

`default_nettype wire

// ----- rtl/ascii_radix_prefixed_integer_parser_core.sv -----
// Top level of the ASCII radix-prefixed integer parser.
//
// Input channel: one ASCII byte per word on i_char_in (i_valid / o_ready).
// Leading blanks are skipped, an optional '-' follows, then '$' for hex,
// '%' for binary, or decimal digits. A zero byte ends the string.
// Output channel: one word per terminator, o_value (32-bit two's complement,
// wrapped) and o_ok (o_valid / i_ready). A bad byte gives o_value 0, o_ok 0.
// Throughput: one byte per cycle while the work queue has room; the front end
// classifies a byte in the cycle it is accepted and the back end does one
// shift-add per cycle. A terminator's work word passes through the work queue
// and then loads the output register, which raises o_valid; a stalled
// receiver can hold that word in the queue.
// Reset (i_rst_n low, synchronous) returns the parse to whitespace skipping,
// clears the accumulator, empties the queue and drops o_valid.
// When the receiver stalls, the held result stays on the outputs; bytes keep
// flowing until a second terminator reaches the head of the queue and the
// two-word queue fills, then o_ready drops.
`timescale 1ns / 1ps
`default_nettype none

`include "ascii_radix_prefixed_integer_parser_core_macros.svh"

module ascii_radix_prefixed_integer_parser_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [arpi_pkg::CHAR_BITS-1:0]        i_char_in,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [arpi_pkg::VALUE_BITS-1:0] o_value,
    output logic                                  o_ok
);
    import arpi_pkg::*;

    logic q_push;
    logic q_not_full;
    logic q_valid;
    logic q_pop;
    t_op  front_op;
    t_op  q_op;
    logic fail_out;
    logic term_held;

    arpi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_char_in (i_char_in),
        .o_push    (q_push),
        .o_op      (front_op),
        .i_q_ready (q_not_full)
    );

    arpi_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_op       (front_op),
        .o_not_full (q_not_full),
        .o_valid    (q_valid),
        .o_op       (q_op),
        .i_pop      (q_pop)
    );

    arpi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (o_value),
        .o_ok      (o_ok)
    );

    assign fail_out  = o_valid && !o_ok;
    assign term_held = q_valid && (q_op.kind == OP_TERM) && o_valid && !i_ready;

    `ARPI_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, fail_out, o_value == '0, "failed parse not zero")
    `ARPI_ASSERT_NOW(a_stall_has_work, i_clk, i_rst_n, !o_ready, q_valid, "stall with empty queue")
    `ARPI_ASSERT_NOW(a_no_term_overrun, i_clk, i_rst_n, term_held, !q_pop, "term over held word")

endmodule

`default_nettype wire

// ----- rtl/arpi_front.sv -----
// Front end: tracks the parse phase and turns digits, the sign and the terminator into work words.
`timescale 1ns / 1ps
`default_nettype none

module arpi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [arpi_pkg::CHAR_BITS-1:0] i_char_in,
    output logic                          o_push,
    output arpi_pkg::t_op                 o_op,
    input  logic                          i_q_ready
);
    import arpi_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_HEX,
        PH_BIN,
        PH_DEC,
        PH_FAIL
    } t_phase;

    t_phase                r_phase;
    t_phase                n_phase;
    logic                  emit;
    logic                  accept;
    logic                  is_dec;
    logic                  is_hex_alpha;
    logic [CHAR_BITS-1:0]  lc;
    t_op                   op;

    assign lc           = i_char_in | CASE_BIT;
    assign is_dec       = (i_char_in >= CH_ZERO) && (i_char_in <= CH_NINE);
    assign is_hex_alpha = (lc >= CH_LC_A) && (lc <= CH_LC_F);
    assign accept       = i_valid && i_q_ready;

    always_comb begin
        n_phase  = r_phase;
        emit     = 1'b0;
        op.kind  = OP_DIGIT;
        op.radix = RADIX_DEC;
        op.digit = i_char_in[DIGIT_BITS-1:0];
        op.ok    = 1'b1;
        if (i_char_in == CH_NUL) begin
            emit    = 1'b1;
            op.kind = OP_TERM;
            op.ok   = (r_phase != PH_FAIL);
            n_phase = PH_SKIP;
        end else begin
            case (r_phase)
                PH_SKIP, PH_SIGN: begin
                    if (r_phase == PH_SKIP && (i_char_in == CH_SPACE || i_char_in == CH_TAB)) begin
                        n_phase = PH_SKIP;
                    end else if (r_phase == PH_SKIP && i_char_in == CH_MINUS) begin
                        emit    = 1'b1;
                        op.kind = OP_NEG;
                        n_phase = PH_SIGN;
                    end else if (i_char_in == CH_DOLLAR) begin
                        n_phase = PH_HEX;
                    end else if (i_char_in == CH_PCT) begin
                        n_phase = PH_BIN;
                    end else if (is_dec) begin
                        emit    = 1'b1;
                        n_phase = PH_DEC;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_HEX: begin
                    op.radix = RADIX_HEX;
                    if (is_dec) begin
                        emit = 1'b1;
                    end else if (is_hex_alpha) begin
                        emit     = 1'b1;
                        // 'a'..'f' low nibble is 1..6; add 9 for 10..15
                        op.digit = lc[DIGIT_BITS-1:0] + DIGIT_BITS'(9);
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_BIN: begin
                    op.radix = RADIX_BIN;
                    if (i_char_in == CH_ZERO || i_char_in == CH_ONE) begin
                        emit = 1'b1;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_DEC: begin
                    if (is_dec) begin
                        emit = 1'b1;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                default: begin
                    n_phase = PH_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = accept && emit;
    assign o_op    = op;

endmodule

`default_nettype wire

// ----- rtl/arpi_queue.sv -----
// Small FIFO of work words between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module arpi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  arpi_pkg::t_op i_op,
    output logic          o_not_full,
    output logic          o_valid,
    output arpi_pkg::t_op o_op,
    input  logic          i_pop
);
    import arpi_pkg::*;

    t_op                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_pop;

    assign o_valid    = (r_count != '0);
    assign o_not_full = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_op       = r_mem[r_rd_ptr];
    assign do_pop     = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/arpi_back.sv -----
// Back end: accumulates digits and registers the result word.
`timescale 1ns / 1ps
`default_nettype none

module arpi_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  arpi_pkg::t_op                         i_op,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [arpi_pkg::VALUE_BITS-1:0] o_value,
    output logic                                  o_ok
);
    import arpi_pkg::*;

    logic [VALUE_BITS-1:0]        r_acc;
    logic                         r_neg;
    logic                         r_out_valid;
    logic signed [VALUE_BITS-1:0] r_value;
    logic                         r_ok;
    logic [VALUE_BITS-1:0]        scaled;
    logic [VALUE_BITS-1:0]        n_acc;
    logic [VALUE_BITS-1:0]        result;
    logic                         out_free;

    assign out_free = !r_out_valid || i_ready;
    // A terminator needs the output register; other words always drain.
    assign o_pop    = i_q_valid && ((i_op.kind != OP_TERM) || out_free);

    always_comb begin
        case (i_op.radix)
            RADIX_BIN: scaled = r_acc << 1;
            RADIX_HEX: scaled = r_acc << 4;
            RADIX_DEC: scaled = (r_acc << 3) + (r_acc << 1);
            default:   scaled = r_acc;
        endcase
        n_acc = scaled + VALUE_BITS'(i_op.digit);
    end

    always_comb begin
        if (!i_op.ok) begin
            result = '0;
        end else if (r_neg) begin
            result = '0 - r_acc;
        end else begin
            result = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                case (i_op.kind)
                    OP_DIGIT: r_acc <= n_acc;
                    OP_NEG:   r_neg <= 1'b1;
                    OP_TERM: begin
                        r_acc       <= '0;
                        r_neg       <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                    default: r_acc <= r_acc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.kind == OP_TERM) begin
            r_value <= result;
            r_ok    <= i_op.ok;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;
    assign o_ok    = r_ok;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the ASCII radix-prefixed integer parser core.
`timescale 1ns / 1ps

module tb_top;
    import arpi_pkg::*;

    typedef logic [CHAR_BITS-1:0] t_text[$];

    typedef enum logic [2:0] {
        SCAN_BLANK,
        SCAN_SIGN,
        SCAN_HEX,
        SCAN_BIN,
        SCAN_DEC,
        SCAN_BAD
    } t_scan;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic                         ok;
    } t_parse_result;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    // Tracks the parse of each accepted word and queues the value a terminator yields.
    class parse_scoreboard;
        t_scan                  scan;
        logic                   negative;
        logic [VALUE_BITS-1:0]  acc;
        t_parse_result          expected_values[$];
        int                     mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            scan     = SCAN_BLANK;
            negative = 1'b0;
            acc      = '0;
        endfunction

        function void push_digit(logic [VALUE_BITS-1:0] radix, logic [VALUE_BITS-1:0] d);
            acc = acc * radix + d;
        endfunction

        // First byte after the blanks or the sign: prefix or decimal digit.
        function void start_digits(logic [CHAR_BITS-1:0] c);
            if (c == CH_DOLLAR) begin
                scan = SCAN_HEX;
            end else if (c == CH_PCT) begin
                scan = SCAN_BIN;
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                scan = SCAN_DEC;
                push_digit(10, VALUE_BITS'(c - CH_ZERO));
            end else begin
                scan = SCAN_BAD;
            end
        endfunction

        function void take_char(logic [CHAR_BITS-1:0] c);
            logic [CHAR_BITS-1:0] lc;
            t_parse_result        r;
            if (c == CH_NUL) begin
                r.ok    = (scan <= SCAN_DEC);
                r.value = !r.ok ? '0 : (negative ? -acc : acc);
                expected_values.push_back(r);
                restart();
            end else begin
                case (scan)
                    SCAN_BLANK: begin
                        if (c == CH_MINUS) begin
                            negative = 1'b1;
                            scan     = SCAN_SIGN;
                        end else if (c != CH_SPACE && c != CH_TAB) begin
                            start_digits(c);
                        end
                    end
                    SCAN_SIGN: start_digits(c);
                    SCAN_HEX: begin
                        lc = c | CASE_BIT;
                        if (c >= CH_ZERO && c <= CH_NINE)
                            push_digit(16, VALUE_BITS'(c - CH_ZERO));
                        else if (lc >= CH_LC_A && lc <= CH_LC_F)
                            push_digit(16, VALUE_BITS'(lc - CH_LC_A + 8'd10));
                        else
                            scan = SCAN_BAD;
                    end
                    SCAN_BIN: begin
                        if (c == CH_ZERO || c == CH_ONE)
                            push_digit(2, VALUE_BITS'(c - CH_ZERO));
                        else
                            scan = SCAN_BAD;
                    end
                    SCAN_DEC: begin
                        if (c >= CH_ZERO && c <= CH_NINE)
                            push_digit(10, VALUE_BITS'(c - CH_ZERO));
                        else
                            scan = SCAN_BAD;
                    end
                    default: scan = SCAN_BAD;
                endcase
            end
        endfunction

        function void check_value(logic signed [VALUE_BITS-1:0] value, logic ok);
            t_parse_result r;
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %0d ok %0b", value, ok);
            end else begin
                r = expected_values.pop_front();
                if (r.value !== value || r.ok !== ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %0d ok %0b, got value %0d ok %0b",
                                 r.value, r.ok, value, ok);
                end
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          i_valid   = 1'b0;
    logic [CHAR_BITS-1:0]          i_char_in = '0;
    logic                          i_ready   = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic signed [VALUE_BITS-1:0]  o_value;
    logic                          o_ok;

    parse_scoreboard board = new();

    int sender_idle_pct = 0;
    int ready_stall_pct = 0;
    bit hold_req        = 1'b0;
    int hold_left       = 0;

    ascii_radix_prefixed_integer_parser_core i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_char_in (i_char_in),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (o_value),
        .o_ok      (o_ok)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                board.take_char(i_char_in);
            if (o_valid && i_ready)
                board.check_value(o_value, o_ok);
        end
    end

    // Returns at the edge where the word is accepted; valid stays up for a back-to-back word.
    task automatic send_char(input logic [CHAR_BITS-1:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 50)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k]);
        send_char(CH_NUL);
    endtask

    task automatic send_queue(input t_text s);
        foreach (s[k])
            send_char(s[k]);
    endtask

    // One edge first so the last accepted word is already on the scoreboard.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_BITS-1:0] rand_digit(int radix);
        int d;
        d = $urandom_range(radix - 1);
        if (d < 10)
            return CHAR_BITS'(CH_ZERO + d);
        // hex letter, random case
        return CHAR_BITS'(CH_LC_A + d - 10) ^ ($urandom_range(1) ? CASE_BIT : 8'h00);
    endfunction

    // Mostly well-formed strings with random content; some noise and corrupted ones.
    function automatic t_text build_string();
        t_text s;
        int    kind;
        int    radix_sel;
        int    n;
        int    pos;
        kind = $urandom_range(99);
        if (kind < 10) begin
            n = $urandom_range(1, 8);
            repeat (n) s.push_back(CHAR_BITS'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 2))
                s.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            if ($urandom_range(1))
                s.push_back(CH_MINUS);
            radix_sel = $urandom_range(2);
            case (radix_sel)
                0: begin
                    s.push_back(CH_DOLLAR);
                    n = ($urandom_range(3) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
                    repeat (n) s.push_back(rand_digit(16));
                end
                1: begin
                    s.push_back(CH_PCT);
                    n = ($urandom_range(3) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
                    repeat (n) s.push_back(rand_digit(2));
                end
                default: begin
                    n = ($urandom_range(3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
                    repeat (n) s.push_back(rand_digit(10));
                end
            endcase
            if (kind < 30) begin
                pos = $urandom_range(s.size());
                s.insert(pos, CHAR_BITS'($urandom_range(1, 255)));
            end
        end
        s.push_back(CH_NUL);
        return s;
    endfunction

    task automatic run_random(input int idle_pct, input int stall_pct, input int n_items);
        t_text s;
        int    sent;
        sender_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            s = build_string();
            send_queue(s);
            sent += s.size();
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings
        send_text("");
        send_text("-");
        send_text("-%");
        send_text(" \t-$7fFFffff");
        send_text("- ");
        send_text("--");
        send_text("%12");
        send_text("\377");
        drain();

        run_random(0, 0, 210);
        run_random(70, 0, 210);

        // long receiver hold-off while the sender keeps pushing words
        sender_idle_pct = 0;
        ready_stall_pct = 0;
        hold_req = 1'b1;
        run_random(0, 0, 60);

        run_random(0, 70, 210);
        run_random(8, 8, 210);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
